>>> hdl/esc_pkg.sv
// Shared types, constants and helpers for the sensor compensation block.
package esc_pkg;

	typedef struct packed {
		logic [19:0] raw_temp;
		logic [19:0] raw_press;
		logic [15:0] raw_hum;
	} in_t;

	typedef struct packed {
		logic signed [31:0] temp_centi;
		logic        [31:0] press_q24_8;
		logic        [16:0] hum_q22_10;
	} out_t;

	typedef struct packed {
		logic [47:0] temp_trim;
		logic [63:0] press_trim_low;
		logic [63:0] press_trim_high;
		logic [47:0] mixed_trim;
		logic [39:0] hum_trim;
	} trim_t;

	// item handed from the front part to the pressure back part
	typedef struct packed {
		logic [31:0] tf;
		logic [19:0] raw_press;
		logic [31:0] temp;
		logic [16:0] hum;
	} mid_t;

	localparam logic [2:0] CFG_TEMP_TRIM       = 3'd0;
	localparam logic [2:0] CFG_PRESS_TRIM_LOW  = 3'd1;
	localparam logic [2:0] CFG_PRESS_TRIM_HIGH = 3'd2;
	localparam logic [2:0] CFG_MIXED_TRIM      = 3'd3;
	localparam logic [2:0] CFG_HUM_TRIM        = 3'd4;

	localparam logic [31:0] TF_PRESS_OFS = 32'd128000;
	localparam logic [31:0] TF_HUM_OFS   = 32'd76800;
	localparam logic [31:0] HUM_RND      = 32'd16384;
	localparam logic [31:0] HUM_C_OFS    = 32'd32768;
	localparam logic [31:0] HUM_D_OFS    = 32'd2097152;
	localparam logic [31:0] HUM_E_RND    = 32'd8192;
	localparam logic [31:0] HUM_MAX      = 32'd419430400;
	localparam logic [63:0] PRESS_FULL   = 64'd1048576;
	localparam logic [63:0] PRESS_SCALE  = 64'd3125;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		logic signed [31:0] s;
		s = $signed(x) >>> n;
		return s;
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
		logic signed [63:0] s;
		s = $signed(x) >>> n;
		return s;
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	function automatic logic [63:0] sx16w(input logic [15:0] x);
		return {{48{x[15]}}, x};
	endfunction

endpackage

>>> hdl/env_sensor_compensation_top.sv
// Top level of the sensor trim compensation block.
// Path: 10 front stages, then the queue, then the pressure sequencer, which takes one item at
// a time: ten 64-bit products (six with a zero pressure divisor) on the shared 32x32
// multiplier and one divide on the divider, which a zero divisor skips.
// The front accepts every cycle until the queue fills; reset empties all and zeroes the trims.
module env_sensor_compensation_top #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  esc_pkg::in_t  sample,
	output logic          empty,
	input  logic          pop,
	output esc_pkg::out_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	import esc_pkg::*;

	trim_t trim_q;
	logic  mid_push, mid_full, mid_pop, mid_empty;
	mid_t  mid_wdata, mid_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TEMP_TRIM:       trim_q.temp_trim       <= cfg_data[47:0];
				CFG_PRESS_TRIM_LOW:  trim_q.press_trim_low  <= cfg_data;
				CFG_PRESS_TRIM_HIGH: trim_q.press_trim_high <= cfg_data;
				CFG_MIXED_TRIM:      trim_q.mixed_trim      <= cfg_data[47:0];
				CFG_HUM_TRIM:        trim_q.hum_trim        <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	esc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample   (sample),
		.trim     (trim_q),
		.mid_push (mid_push),
		.mid_full (mid_full),
		.mid_item (mid_wdata)
	);

	esc_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.rd     (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	esc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.trim      (trim_q),
		.mid_empty (mid_empty),
		.mid_item  (mid_rdata),
		.mid_pop   (mid_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

>>> hdl/esc_front.sv
// Front part: accepts items, derives fine temperature, temperature and humidity.
module esc_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  esc_pkg::in_t sample,
	input  esc_pkg::trim_t trim,
	output logic         mid_push,
	input  logic         mid_full,
	output esc_pkg::mid_t mid_item
);
	import esc_pkg::*;

	logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
	logic        en;
	logic [9:0]  v_q;

	// stage registers
	logic [31:0] dx1, m1_s1, sq_s1;
	logic [19:0] rp_s1, rp_s2, rp_s3;
	logic [15:0] rh_s1, rh_s2, rh_s3;
	logic [31:0] a1_s2, m2_s2;
	logic [31:0] tf_s3;
	logic [31:0] hb_s4, hc_s4, ha_s4;
	logic [31:0] ha_s5, pr_s5, ha_s6, m_s6, hv_s7, hv_s8, sq_s8, hv_s9, m3_s9;
	logic [31:0] vh4, hd6, he7, vs8, vv10, vc10;
	mid_t        ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9, ctx_s10;

	assign t1 = {16'b0, trim.temp_trim[15:0]};
	assign t2 = sx16(trim.temp_trim[31:16]);
	assign t3 = sx16(trim.temp_trim[47:32]);
	assign h1 = {24'b0, trim.mixed_trim[23:16]};
	assign h2 = sx16(trim.mixed_trim[39:24]);
	assign h3 = {24'b0, trim.mixed_trim[47:40]};
	assign h4 = sx16(trim.hum_trim[15:0]);
	assign h5 = sx16(trim.hum_trim[31:16]);
	assign h6 = {{24{trim.hum_trim[39]}}, trim.hum_trim[39:32]};

	// freeze the whole pipe while the last item cannot leave
	assign en       = !(v_q[9] && mid_full);
	assign full     = !en;
	assign mid_push = v_q[9] && !mid_full;
	assign mid_item = ctx_s10;

	assign dx1  = {16'b0, sample.raw_temp[19:4]} - t1;
	assign vh4  = tf_s3 - TF_HUM_OFS;
	assign hd6  = asr32(pr_s5, 10) + HUM_D_OFS;
	assign he7  = asr32(m_s6 + HUM_E_RND, 14);
	assign vs8  = asr32(hv_s7, 15);
	assign vv10 = hv_s9 - asr32(m3_s9, 4);
	assign vc10 = vv10[31] ? 32'd0 : ((vv10 > HUM_MAX) ? HUM_MAX : vv10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[8:0], push};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= ({15'b0, sample.raw_temp[19:3]} - {15'b0, t1[15:0], 1'b0}) * t2;
			sq_s1 <= dx1 * dx1;
			rp_s1 <= sample.raw_press;
			rh_s1 <= sample.raw_hum;

			a1_s2 <= asr32(m1_s1, 11);
			m2_s2 <= asr32(sq_s1, 12) * t3;
			rp_s2 <= rp_s1;
			rh_s2 <= rh_s1;

			tf_s3 <= a1_s2 + asr32(m2_s2, 14);
			rp_s3 <= rp_s2;
			rh_s3 <= rh_s2;

			hb_s4   <= vh4 * h6;
			hc_s4   <= vh4 * h3;
			ha_s4   <= ({2'b0, rh_s3, 14'b0}) - (h4 << 20) - h5 * vh4 + HUM_RND;
			ctx_s4.tf        <= tf_s3;
			ctx_s4.raw_press <= rp_s3;
			ctx_s4.temp      <= asr32(tf_s3 * 32'd5 + 32'd128, 8);
			ctx_s4.hum       <= '0;

			ha_s5  <= asr32(ha_s4, 15);
			pr_s5  <= asr32(hb_s4, 10) * (asr32(hc_s4, 11) + HUM_C_OFS);
			ctx_s5 <= ctx_s4;

			ha_s6  <= ha_s5;
			m_s6   <= hd6 * h2;
			ctx_s6 <= ctx_s5;

			hv_s7  <= ha_s6 * he7;
			ctx_s7 <= ctx_s6;

			hv_s8  <= hv_s7;
			sq_s8  <= vs8 * vs8;
			ctx_s8 <= ctx_s7;

			hv_s9  <= hv_s8;
			m3_s9  <= asr32(sq_s8, 7) * h1;
			ctx_s9 <= ctx_s8;

			ctx_s10.tf        <= ctx_s9.tf;
			ctx_s10.raw_press <= ctx_s9.raw_press;
			ctx_s10.temp      <= ctx_s9.temp;
			ctx_s10.hum       <= vc10[28:12];
		end
	end

endmodule

>>> hdl/esc_fifo.sv
// Small queue between the front and back parts.
module esc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  esc_pkg::mid_t wdata,
	output logic          full,
	input  logic          rd,
	output esc_pkg::mid_t rdata,
	output logic          empty
);
	import esc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	mid_t          mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem[wp_q] <= wdata;
	end

endmodule

>>> hdl/esc_mul64.sv
// Shared 64x64 multiply, low 64 bits, one 32x32 partial product per cycle while go is high.
module esc_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	logic [1:0]  ph_q;
	logic [31:0] opx, opy;
	logic [63:0] prod;
	logic [63:0] pp0_q;
	logic [31:0] pp1_q, pp2_q;

	always_comb begin
		unique case (ph_q)
			2'd0:    begin opx = a[31:0];  opy = b[31:0];  end
			2'd1:    begin opx = a[31:0];  opy = b[63:32]; end
			default: begin opx = a[63:32]; opy = b[31:0];  end
		endcase
	end

	assign prod = opx * opy;
	assign done = go && (ph_q == 2'd3);
	assign p    = pp0_q + {pp1_q + pp2_q, 32'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= '0;
		end else if (go) begin
			ph_q <= ph_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (ph_q)
			2'd0:    pp0_q <= prod;
			2'd1:    pp1_q <= prod[31:0];
			2'd2:    pp2_q <= prod[31:0];
			default: ;
		endcase
	end

endmodule

>>> hdl/esc_div64.sv
// Signed 64-bit divider, truncating, one quotient bit per cycle while busy.
module esc_div64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	input  logic [63:0] d,
	output logic        done,
	output logic [63:0] q
);
	logic        busy_q, done_q, neg_q;
	logic [6:0]  cnt_q;
	logic [63:0] ud_q, quo_q;
	logic [64:0] rem_q, sh;
	logic        ge;

	assign sh   = {rem_q[63:0], quo_q[63]};
	assign ge   = sh >= {1'b0, ud_q};
	assign done = done_q;
	assign q    = neg_q ? (64'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= n[63] ^ d[63];
			ud_q  <= d[63] ? 64'd0 - d : d;
			quo_q <= n[63] ? 64'd0 - n : n;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? sh - {1'b0, ud_q} : sh;
			quo_q <= {quo_q[62:0], ge};
		end
	end

endmodule

>>> hdl/esc_back.sv
// Back part: sequences the 64-bit pressure compensation and holds the result.
module esc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  esc_pkg::trim_t trim,
	input  logic           mid_empty,
	input  esc_pkg::mid_t  mid_item,
	output logic           mid_pop,
	output logic           empty,
	input  logic           pop,
	output esc_pkg::out_t  result
);
	import esc_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_SUM, ST_FIN, ST_HOLD} state_t;

	state_t      state_q;
	logic [3:0]  step_q;
	logic [63:0] v1_q, s_q, v2_q, a_q, b_q, npre_q, p_q, ps_q, x_q, w1_q, w2_q, sum_q;
	logic [19:0] rp_q;
	logic [31:0] temp_q, press_q;
	logic [16:0] hum_q;
	logic        ovalid_q;
	out_t        out_q;

	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [63:0] ma, mb, mr, dq, bnew;
	logic        mgo, mdone, dstart, ddone, load;

	assign p1 = {48'b0, trim.press_trim_low[15:0]};
	assign p2 = sx16w(trim.press_trim_low[31:16]);
	assign p3 = sx16w(trim.press_trim_low[47:32]);
	assign p4 = sx16w(trim.press_trim_low[63:48]);
	assign p5 = sx16w(trim.press_trim_high[15:0]);
	assign p6 = sx16w(trim.press_trim_high[31:16]);
	assign p7 = sx16w(trim.press_trim_high[47:32]);
	assign p8 = sx16w(trim.press_trim_high[63:48]);
	assign p9 = sx16w(trim.mixed_trim[15:0]);

	always_comb begin
		unique case (step_q)
			4'd0:    begin ma = v1_q;                   mb = v1_q;        end
			4'd1:    begin ma = s_q;                    mb = p6;          end
			4'd2:    begin ma = v1_q;                   mb = p5;          end
			4'd3:    begin ma = s_q;                    mb = p3;          end
			4'd4:    begin ma = v1_q;                   mb = p2;          end
			4'd5:    begin ma = (64'd1 << 47) + a_q;    mb = p1;          end
			4'd6:    begin ma = npre_q;                 mb = PRESS_SCALE; end
			4'd7:    begin ma = p9;                     mb = ps_q;        end
			4'd8:    begin ma = x_q;                    mb = ps_q;        end
			4'd9:    begin ma = p8;                     mb = p_q;         end
			default: begin ma = '0;                     mb = '0;          end
		endcase
	end

	assign mgo     = (state_q == ST_MUL);
	assign dstart  = mdone && (step_q == 4'd6);
	assign bnew    = asr64(mr, 33);
	assign mid_pop = (state_q == ST_IDLE) && !mid_empty;
	assign load    = (state_q == ST_HOLD) && (!ovalid_q || pop);
	assign empty   = !ovalid_q;
	assign result  = out_q;

	esc_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mgo),
		.a      (ma),
		.b      (mb),
		.done   (mdone),
		.p      (mr)
	);

	esc_div64 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.n      (mr),
		.d      (b_q),
		.done   (ddone),
		.q      (dq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) ovalid_q <= 1'b1;
			else if (pop) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!mid_empty) begin
						state_q <= ST_MUL;
						step_q  <= 4'd0;
					end
				end
				ST_MUL: begin
					if (mdone) begin
						priority if (step_q == 4'd5 && bnew == '0) begin
							state_q <= ST_HOLD;
						end else if (step_q == 4'd6) begin
							state_q <= ST_DIV;
						end else if (step_q == 4'd9) begin
							state_q <= ST_SUM;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (ddone) begin
						state_q <= ST_MUL;
						step_q  <= 4'd7;
					end
				end
				ST_SUM:  state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_HOLD;
				ST_HOLD: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			v1_q    <= {{32{mid_item.tf[31]}}, mid_item.tf} - {32'b0, TF_PRESS_OFS};
			rp_q    <= mid_item.raw_press;
			temp_q  <= mid_item.temp;
			hum_q   <= mid_item.hum;
			press_q <= '0;
		end
		if (mgo && mdone) begin
			unique case (step_q)
				4'd0: s_q  <= mr;
				4'd1: v2_q <= mr;
				4'd2: v2_q <= v2_q + (mr << 17) + (p4 << 35);
				4'd3: a_q  <= asr64(mr, 8);
				4'd4: a_q  <= a_q + (mr << 12);
				4'd5: begin
					b_q    <= bnew;
					npre_q <= ((PRESS_FULL - {44'b0, rp_q}) << 31) - v2_q;
				end
				4'd7: x_q  <= mr;
				4'd8: w1_q <= asr64(mr, 25);
				4'd9: w2_q <= asr64(mr, 19);
				default: ;
			endcase
		end
		if (state_q == ST_DIV && ddone) begin
			p_q  <= dq;
			ps_q <= asr64(dq, 13);
		end
		if (state_q == ST_SUM) sum_q <= p_q + w1_q + w2_q;
		if (state_q == ST_FIN) press_q <= 32'(asr64(sum_q, 8) + (p7 << 4));
		if (load) begin
			out_q.temp_centi  <= temp_q;
			out_q.press_q24_8 <= press_q;
			out_q.hum_q22_10  <= hum_q;
		end
	end

endmodule

>>> dv/testbench.sv
// Scoreboard and stimulus for the sensor trim compensation block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import esc_pkg::*;

	localparam int ITEMS     = 1900;
	localparam int WDOG_MAX  = 20000;
	localparam int TAIL      = 200;
	localparam int MAX_SHOWN = 10;

	// Compensation predictor and queue of expected readings.
	class comp_scoreboard;
		logic [47:0] temp_trim;
		logic [63:0] press_lo;
		logic [63:0] press_hi;
		logic [47:0] mixed_trim;
		logic [39:0] hum_trim;
		out_t        pending[$];
		int          errors;

		function void set_trim(logic [2:0] idx, logic [63:0] val);
			case (idx)
				CFG_TEMP_TRIM:       temp_trim  = val[47:0];
				CFG_PRESS_TRIM_LOW:  press_lo   = val;
				CFG_PRESS_TRIM_HIGH: press_hi   = val;
				CFG_MIXED_TRIM:      mixed_trim = val[47:0];
				CFG_HUM_TRIM:        hum_trim   = val[39:0];
				default: ;
			endcase
		endfunction

		function out_t compensate(in_t s);
			logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
			logic signed [31:0] dx, a1, a2, tf, v, ha, hb, hc, hd, he, vs;
			logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
			logic signed [63:0] w1, w2, x1, x2, p, ps, q1, q2, num;
			logic [63:0] un, ud;
			out_t r;
			t1 = {16'd0, temp_trim[15:0]};
			t2 = $signed(temp_trim[31:16]);
			t3 = $signed(temp_trim[47:32]);
			p1 = {48'd0, press_lo[15:0]};
			p2 = $signed(press_lo[31:16]);
			p3 = $signed(press_lo[47:32]);
			p4 = $signed(press_lo[63:48]);
			p5 = $signed(press_hi[15:0]);
			p6 = $signed(press_hi[31:16]);
			p7 = $signed(press_hi[47:32]);
			p8 = $signed(press_hi[63:48]);
			p9 = $signed(mixed_trim[15:0]);
			h1 = {24'd0, mixed_trim[23:16]};
			h2 = $signed(mixed_trim[39:24]);
			h3 = {24'd0, mixed_trim[47:40]};
			h4 = $signed(hum_trim[15:0]);
			h5 = $signed(hum_trim[31:16]);
			h6 = $signed(hum_trim[39:32]);

			dx = {16'd0, s.raw_temp[19:4]} - t1;
			a1 = $signed(32'(({15'd0, s.raw_temp[19:3]} - (t1 << 1)) * t2)) >>> 11;
			a2 = (((dx * dx) >>> 12) * t3) >>> 14;
			tf = a1 + a2;
			r.temp_centi = (tf * 5 + 128) >>> 8;

			x1 = 64'(tf) - 64'sd128000;
			x2 = x1 * x1 * p6;
			x2 = x2 + ((x1 * p5) << 17);
			x2 = x2 + (p4 << 35);
			x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) << 12);
			x1 = (((64'sd1 <<< 47) + x1) * p1) >>> 33;
			r.press_q24_8 = '0;
			if (x1 != 0) begin
				p = 64'sd1048576 - {44'd0, s.raw_press};
				num = ((p << 31) - x2) * 64'sd3125;
				un = num[63] ? -num : num;
				ud = x1[63] ? -x1 : x1;
				p = un / ud;
				if (num[63] != x1[63])
					p = -p;
				ps = p >>> 13;
				q1 = (p9 * ps * ps) >>> 25;
				q2 = (p8 * p) >>> 19;
				p = ((p + q1 + q2) >>> 8) + (p7 << 4);
				r.press_q24_8 = p[31:0];
			end

			v = tf - 32'sd76800;
			ha = $signed(32'(({16'd0, s.raw_hum} << 14) - (h4 << 20) - h5 * v + 32'sd16384))
				>>> 15;
			hb = (v * h6) >>> 10;
			hc = ((v * h3) >>> 11) + 32'sd32768;
			hd = ((hb * hc) >>> 10) + 32'sd2097152;
			he = (hd * h2 + 32'sd8192) >>> 14;
			v = ha * he;
			vs = v >>> 15;
			v = v - ((((vs * vs) >>> 7) * h1) >>> 4);
			if (v < 0)
				v = 0;
			if (v > 32'sd419430400)
				v = 32'sd419430400;
			r.hum_q22_10 = v[28:12];
			return r;
		endfunction

		function void note_sample(in_t s);
			pending.push_back(compensate(s));
		endfunction

		function void check_reading(out_t got);
			out_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected reading %h", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("mismatch: temp %0d/%0d press %h/%h hum %h/%h",
						exp_r.temp_centi, got.temp_centi, exp_r.press_q24_8,
						got.press_q24_8, exp_r.hum_q22_10, got.hum_q22_10);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic        full, empty, cfg_ready;
	in_t         sample = '0;
	out_t        result;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	comp_scoreboard board;
	int          idle_cycles = 0;
	bit          feeding_done;

	always #4 clk = ~clk;

	env_sensor_compensation_top DUT (
		.clk, .arst_n, .push, .full, .sample, .empty, .pop, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 4)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 150);
		return $urandom_range(1, 4);
	endfunction

	// Result side: pop with random stalls, check each accepted reading.
	initial begin
		bit burst;
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_reading(result);
			burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : pick_gap();
			pop <= (gap == 0);
		end
	end

	// Watchdog on accepted traffic.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Leave valid high; the caller drops it after the last write.
	task automatic write_trim(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_trim(idx, val);
	endtask

	task automatic send_sample(in_t s, int gap);
		push <= 1'b1;
		sample <= s;
		do @(posedge clk); while (full);
		board.note_sample(s);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	function automatic in_t rand_sample();
		in_t s;
		s.raw_temp = 20'($urandom());
		s.raw_press = 20'($urandom());
		s.raw_hum = 16'($urandom());
		return s;
	endfunction

	// All-zero, all-one or raw random words, or factory-like trims with random jitter.
	task automatic load_trims(int mode);
		logic [63:0] w[5];
		if (mode == 0) begin
			foreach (w[i]) w[i] = '0;
		end else if (mode == 1) begin
			foreach (w[i]) w[i] = '1;
		end else if (mode == 2) begin
			foreach (w[i]) w[i] = {$urandom(), $urandom()};
		end else begin
			w[0] = {16'(-16'sd1000 + $urandom_range(0, 2000)),
				16'(26000 + $urandom_range(0, 2000)), 16'(27000 + $urandom_range(0, 2000))};
			w[1] = {16'(2800 + $urandom_range(0, 200)), 16'(-16'sd7000),
				16'(-16'sd10600 + $urandom_range(0, 200)), 16'(36000 + $urandom_range(0, 2000))};
			w[2] = {16'(-16'sd7 - $urandom_range(0, 10)), 16'(15500 + $urandom_range(0, 200)),
				16'(-16'sd4), 16'(140 + $urandom_range(0, 20))};
			w[3] = {8'd0, 16'(360 + $urandom_range(0, 20)), 8'd75, 16'(6000)};
			w[4] = {8'd30, 16'(50), 16'(320 + $urandom_range(0, 20))};
			if (mode == 4)
				w[1][15:0] = '0; // zero pressure divisor
		end
		write_trim(CFG_TEMP_TRIM, w[0]);
		write_trim(CFG_PRESS_TRIM_LOW, w[1]);
		write_trim(CFG_PRESS_TRIM_HIGH, w[2]);
		write_trim(CFG_MIXED_TRIM, w[3]);
		write_trim(CFG_HUM_TRIM, w[4]);
		if ($urandom_range(0, 1))
			write_trim(3'd5 + 3'($urandom_range(0, 2)), {$urandom(), $urandom()});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		in_t s;
		int sent;
		int phase;
		board = new();
		board.set_trim(CFG_TEMP_TRIM, '0);
		board.set_trim(CFG_PRESS_TRIM_LOW, '0);
		board.set_trim(CFG_PRESS_TRIM_HIGH, '0);
		board.set_trim(CFG_MIXED_TRIM, '0);
		board.set_trim(CFG_HUM_TRIM, '0);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset and all-zero trims, then typical, all-ones and zero-divisor trims at field extremes
		for (int m = 0; m < 5; m++) begin
			if (m > 0)
				load_trims(m == 2 ? 3 : (m == 3 ? 1 : (m == 4 ? 4 : 0)));
			s = '0;
			send_sample(s, 0);
			s = '1;
			send_sample(s, 1);
			s = {20'd524288, 20'd415148, 16'd26000};
			send_sample(s, 0);
			s = {20'd0, 20'hFFFFF, 16'd0};
			send_sample(s, 0);
			drain();
		end

		// random phases, paused until drained between trim sets
		sent = 0;
		phase = 0;
		while (sent < ITEMS) begin
			load_trims(phase == 0 ? 3 : (phase % 5 == 2 ? 2 : ($urandom_range(0, 9) == 0 ? 4 : 3)));
			for (int k = 0; k < 120 && sent < ITEMS; k++) begin
				send_sample(rand_sample(), ($urandom_range(0, 2) == 0) ? 0 : pick_gap());
				sent++;
			end
			drain();
			phase++;
		end
		load_trims(0);
		send_sample(rand_sample(), 0);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

>>> files.f
hdl/esc_pkg.sv
hdl/esc_front.sv
hdl/esc_fifo.sv
hdl/esc_mul64.sv
hdl/esc_div64.sv
hdl/esc_back.sv
hdl/env_sensor_compensation_top.sv
dv/testbench.sv
